### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define HVR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define HVR_ASSERT(lbl, prop, msg) `HVR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/hvr_pkg.sv
// Package: widths, constants, register codes and control structs of the resampler.
package hvr_pkg;

  localparam int NUM_CH   = 2;
  localparam int SAMPLE_W = 24;
  localparam int ACC_W    = 30;
  localparam int FRAC_W   = 16;
  localparam int POS_W    = 21;
  localparam int STEP_W   = 20;
  localparam int MAX_OUT  = 64;
  localparam int CNT_W    = $clog2(MAX_OUT);
  localparam int PROD_W   = ACC_W + FRAC_W + 1;
  localparam int FIN_W    = ACC_W + 1;

  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_STEP   = REG_IDX_W'(1);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [POS_W-1:0]  POS_ONE    = POS_W'(1) << FRAC_W;

  // Horner step select
  localparam logic [1:0] MAC_D3  = 2'd0;
  localparam logic [1:0] MAC_D1  = 2'd1;
  localparam logic [1:0] MAC_END = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [FIN_W-1:0]    fin_t;

  localparam acc_t  ACC_ONE   = acc_t'(1);
  localparam prod_t PROD_HALF = prod_t'(1) <<< (FRAC_W - 1);
  localparam fin_t  SAT_MAX   = fin_t'(8388607);
  localparam fin_t  SAT_MIN   = -fin_t'(8388608);

  typedef struct packed {
    logic              enable;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic              win_load;
    logic [1:0]        win_fill;
    logic              coef_load;
    logic              mac_en;
    logic [1:0]        mac_sel;
    logic [FRAC_W-1:0] frac;
    logic              out_load;
    logic              out_last;
  } cmd_t;

endpackage

### rtl/hvr_in_if.sv
// Input channel interface: one stereo source sample per item.
interface hvr_in_if import hvr_pkg::*; ;
  logic    valid;
  logic    ready;
  sample_t sample_left;
  sample_t sample_right;
  logic    restart;

  modport source (output valid, output sample_left, output sample_right, output restart,
                  input ready);
  modport sink (input valid, input sample_left, input sample_right, input restart,
                output ready);
endinterface

### rtl/hvr_out_if.sv
// Output channel interface: one interpolated stereo sample per item.
interface hvr_out_if import hvr_pkg::*; ;
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;
  logic    last;

  modport source (output valid, output out_left, output out_right, output last,
                  input ready);
  modport sink (input valid, input out_left, input out_right, input last,
                output ready);
endinterface

### rtl/hvr_regs.sv
// APB-style configuration registers: enable and step.
module hvr_regs import hvr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic                 enable_q, enable_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    enable_d = enable_q;
    step_d   = step_q;
    prdata   = '0;
    unique case (idx)
      REG_ENABLE: begin
        prdata = APB_DW'(enable_q);
        if (wr_en) enable_d = pwdata[0];
      end
      REG_STEP: begin
        prdata = APB_DW'(step_q);
        if (wr_en) step_d = pwdata[STEP_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      step_q   <= STEP_RESET;
    end else begin
      enable_q <= enable_d;
      step_q   <= step_d;
    end
  end

  assign cfg_o.enable = enable_q;
  assign cfg_o.step   = step_q;

endmodule

### rtl/hvr_ctrl.sv
// Controller: fill count, read position, result sequencing and output valid.
module hvr_ctrl import hvr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  input  logic in_restart_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COEF = 2'd1;
  localparam logic [1:0] S_MAC  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [1:0]       fill_q, fill_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;

  logic [1:0]       fill_eff;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] pos_next;
  logic             is_last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_next    = pos_q + POS_W'(cfg_i.step);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    fill_d       = fill_q;
    pos_d        = pos_q;
    fill_eff     = in_restart_i ? 2'd0 : fill_q;
    pos_eff      = in_restart_i ? '0 : pos_q;
    is_last      = (pos_next >= POS_ONE) || (n_q == CNT_W'(MAX_OUT - 1));
    cmd_o        = '0;
    cmd_o.frac   = pos_q[FRAC_W-1:0];
    cmd_o.mac_sel = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        // items with enable off are taken and dropped
        if (in_valid_i && cfg_i.enable) begin
          cmd_o.win_load = 1'b1;
          cmd_o.win_fill = fill_eff;
          n_d            = '0;
          pos_d          = pos_eff;
          if (fill_eff < 2'd2) begin
            fill_d = fill_eff + 2'd1;
          end else if (fill_eff == 2'd2) begin
            fill_d  = 2'd3;
            state_d = S_COEF;
          end else begin
            // drop position by one sample, floor at zero
            pos_d   = (pos_eff >= POS_ONE) ? (pos_eff - POS_ONE) : '0;
            state_d = S_COEF;
          end
        end
      end
      S_COEF: begin
        cmd_o.coef_load = 1'b1;
        cnt_d           = MAC_D3;
        state_d         = (pos_q < POS_ONE) ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (cnt_q == MAC_END) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      S_OUT: begin
        // hold the finished result until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = is_last;
          pos_d          = pos_next;
          n_d            = n_q + CNT_W'(1);
          cnt_d          = MAC_D3;
          state_d        = is_last ? S_IDLE : S_MAC;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= MAC_D3;
      n_q         <= '0;
      fill_q      <= 2'd0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/hvr_dp.sv
// Datapath: sample windows, Hermite coefficients, Horner steps and output register.
module hvr_dp import hvr_pkg::*; (
  input  logic    clk_i,
  input  cmd_t    cmd_i,
  input  sample_t sample_i [NUM_CH],
  output sample_t res_o [NUM_CH],
  output logic    last_o
);

  logic                last_q;
  logic signed [FRAC_W:0] frac_s;

  assign frac_s = $signed({1'b0, cmd_i.frac});

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    sample_t w_q [4];
    acc_t    d1_q, d2_q, d3_q, acc_q, acc_d;
    acc_t    xm1, x0, x1, x2, diff, d1_c, d2_c, d3_c;
    acc_t    mul_a, addend;
    prod_t   prod, prod_sh;
    fin_t    sum;
    sample_t res_q, res_d;

    always_comb begin
      xm1  = acc_t'(w_q[0]);
      x0   = acc_t'(w_q[1]);
      x1   = acc_t'(w_q[2]);
      x2   = acc_t'(w_q[3]);
      diff = x0 - x1;
      d1_c = x1 - xm1;
      d3_c = diff + (diff <<< 1) + (x2 - xm1);
      d2_c = (xm1 <<< 1) - (x0 <<< 1) + d1_c - d3_c;
    end

    always_comb begin
      case (cmd_i.mac_sel)
        MAC_D3: begin
          mul_a  = d3_q;
          addend = d2_q;
        end
        MAC_D1: begin
          mul_a  = acc_q;
          addend = d1_q;
        end
        default: begin
          mul_a  = acc_q;
          addend = '0;
        end
      endcase
      prod    = mul_a * frac_s;
      // round to nearest, ties up
      prod_sh = (prod + PROD_HALF) >>> FRAC_W;
      acc_d   = $signed(prod_sh[ACC_W-1:0]) + addend;
    end

    always_comb begin
      sum = fin_t'(x0) + fin_t'((acc_q + ACC_ONE) >>> 1);
      if (sum > SAT_MAX) begin
        res_d = sample_t'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
        res_d = sample_t'(SAT_MIN);
      end else begin
        res_d = $signed(sum[SAMPLE_W-1:0]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.win_load) begin
        case (cmd_i.win_fill)
          2'd0: begin
            w_q[0] <= sample_i[c];
            w_q[1] <= sample_i[c];
            w_q[2] <= '0;
            w_q[3] <= '0;
          end
          2'd1: w_q[2] <= sample_i[c];
          2'd2: w_q[3] <= sample_i[c];
          default: begin
            w_q[0] <= w_q[1];
            w_q[1] <= w_q[2];
            w_q[2] <= w_q[3];
            w_q[3] <= sample_i[c];
          end
        endcase
      end
      if (cmd_i.coef_load) begin
        d1_q <= d1_c;
        d2_q <= d2_c;
        d3_q <= d3_c;
      end
      if (cmd_i.mac_en) acc_q <= acc_d;
      if (cmd_i.out_load) res_q <= res_d;
    end

    assign res_o[c] = res_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) last_q <= cmd_i.out_last;
  end

  assign last_o = last_q;

endmodule

### rtl/hermite_varispeed_resampler_top.sv
// Top level: varispeed stereo resampler with 4-point Hermite interpolation.
//
// in_i carries one stereo Q1.23 source sample per item; restart starts a new
// stream with this sample. out_o carries interpolated, saturated samples; last
// marks the final result caused by one input item. The APB port holds enable
// (address 0) and step_q16 (address 4); pready is always high.
// While enable is 0, input items are accepted and dropped.
// The first two samples of a stream give no result. Each item that does give
// results first loads the window, then forms the coefficients, then for each
// result runs three Horner steps on one multiplier per channel and a final
// add and saturation into the output register. An item gives at most MAX_OUT
// results, one after another.
// One item is worked on at a time; in_i.ready is high only between items.
// A finished result waits in the output register while the receiver stalls;
// the next one is computed and held until that register frees up.
// Reset clears enable, sets step to 1.0, and empties fill count and position.
module hermite_varispeed_resampler_top import hvr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  hvr_in_if.sink            in_i,
  hvr_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  sample_t smp [NUM_CH];
  sample_t res [NUM_CH];

  assign smp[0]          = in_i.sample_left;
  assign out_o.out_left  = res[0];

  if (NUM_CH > 1) begin : g_right
    assign smp[1]          = in_i.sample_right;
    assign out_o.out_right = res[1];
  end else begin : g_mono
    assign out_o.out_right = '0;
  end

  hvr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hvr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd)
  );

  hvr_dp u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .sample_i (smp),
    .res_o    (res),
    .last_o   (out_o.last)
  );

endmodule

### rtl/hvr_checker.sv
// Port-level checker for the resampler, bound to the top level.
`include "assert_macros.svh"

module hvr_checker import hvr_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input logic    out_last_i,
  input sample_t out_left_i,
  input sample_t out_right_i
);

  // a stalled result holds its payload
  `HVR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_left_i) && $stable(out_right_i) && $stable(out_last_i), "stalled result changed")

  // no new item while a run of results is still incomplete
  `HVR_ASSERT(a_no_accept_mid_run, out_valid_i && !out_last_i |-> !in_ready_i, "input ready in the middle of a result run")

  // a new result needs window, coefficient and Horner cycles first
  `HVR_ASSERT(a_min_latency, in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i ##1 !out_valid_i ##1 !out_valid_i, "result appeared too soon after an item")

endmodule

bind hermite_varispeed_resampler_top hvr_checker u_hvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last),
  .out_left_i  (out_o.out_left),
  .out_right_i (out_o.out_right)
);

### sim/tb_top.sv
// Self-checking testbench for the Hermite varispeed resampler: directed script, then random streams.
`timescale 1ns / 100ps

module tb_top;
  import hvr_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int QUIET_CYCLES = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int PREDICT      = -1;
  localparam int RAND_PHASES  = 6;
  localparam int RAND_ITEMS   = 24;

  localparam sample_t S_MAX = 24'sh7fffff;
  localparam sample_t S_MIN = 24'sh800000;

  localparam logic [APB_DW-1:0] STEP_UNITY   = 32'd65536;
  localparam logic [APB_DW-1:0] STEP_HALF    = 32'd32768;
  localparam logic [APB_DW-1:0] STEP_MIN     = 32'd1024;
  localparam logic [APB_DW-1:0] STEP_SUB_MIN = 32'd1000;
  localparam logic [APB_DW-1:0] STEP_MAX     = 32'd1048575;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } point_t;

  typedef struct {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [APB_DW-1:0]    reg_val;
    sample_t              left;
    sample_t              right;
    logic                 restart;
    int                   n_typed;
    sample_t              typed_left;
    sample_t              typed_right;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  hvr_in_if  in_if ();
  hvr_out_if out_if ();

  hermite_varispeed_resampler_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // resampler state as the testbench sees it
  logic              model_en;
  logic [STEP_W-1:0] model_step;
  sample_t           model_win [NUM_CH][4];
  int                model_fill;
  logic [POS_W-1:0]  model_pos;

  point_t    pending_points[$];
  stim_row_t script[$];
  sample_t   last_drawn[NUM_CH];
  int        mismatches   = 0;
  int        results_seen = 0;
  int        cycles       = 0;
  int        burst_left   = 0;
  bit        hold_go      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tb_top: mismatch on %s at result %0d: got %0d, want %0d",
             what, results_seen, got, want);
    mismatches++;
  endtask

  // floor((v + 2^(n-1)) / 2^n)
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic sample_t hermite_point(input int ch, input logic [FRAC_W-1:0] frac);
    longint ym1, y0, y1, y2, d1, d2, d3, fr, t, r;
    ym1 = model_win[ch][0];
    y0  = model_win[ch][1];
    y1  = model_win[ch][2];
    y2  = model_win[ch][3];
    fr  = frac;
    d1  = y1 - ym1;
    d3  = 3 * (y0 - y1) + (y2 - ym1);
    d2  = 2 * ym1 - 2 * y0 + d1 - d3;
    t   = round_shift(d3 * fr, FRAC_W) + d2;
    t   = round_shift(t * fr, FRAC_W) + d1;
    t   = round_shift(t * fr, FRAC_W);
    r   = y0 + round_shift(t, 1);
    if (r > S_MAX) r = S_MAX;
    if (r < S_MIN) r = S_MIN;
    return sample_t'(r);
  endfunction

  function automatic void resample_item(input sample_t left, input sample_t right,
                                        input logic restart, output point_t pts[$]);
    sample_t s;
    point_t  pt;
    int      c;
    int      n;
    pts = {};
    n = 0;
    if (!model_en) return;
    if (restart) begin
      foreach (model_win[i, k]) model_win[i][k] = '0;
      model_fill = 0;
      model_pos  = '0;
    end
    for (c = 0; c < NUM_CH; c++) begin
      s = (c == 0) ? left : right;
      case (model_fill)
        0: begin
          model_win[c][0] = s;
          model_win[c][1] = s;
        end
        1: model_win[c][2] = s;
        2: model_win[c][3] = s;
        default: begin
          model_win[c][0] = model_win[c][1];
          model_win[c][1] = model_win[c][2];
          model_win[c][2] = model_win[c][3];
          model_win[c][3] = s;
        end
      endcase
    end
    if (model_fill < 3) begin
      model_fill++;
      if (model_fill < 3) return;
    end else if (model_pos >= POS_ONE) begin
      model_pos = model_pos - POS_ONE;
    end else begin
      model_pos = '0;
    end
    while (model_pos < POS_ONE && n < MAX_OUT) begin
      pt.left  = hermite_point(0, model_pos[FRAC_W-1:0]);
      pt.right = hermite_point(1, model_pos[FRAC_W-1:0]);
      pt.last  = 1'b0;
      pts.push_back(pt);
      n++;
      model_pos = model_pos + POS_W'(model_step);
    end
    if (n > 0) pts[n-1].last = 1'b1;
  endfunction

  function automatic sample_t draw_sample(input int ch);
    sample_t s;
    case ($urandom_range(0, 7))
      0: s = S_MAX;
      1: s = S_MIN;
      2, 3: s = sample_t'($urandom);
      default: s = last_drawn[ch] + sample_t'(int'($urandom_range(0, 131071)) - 65536);
    endcase
    last_drawn[ch] = s;
    return s;
  endfunction

  function automatic void add_item(input sample_t l, r, input logic rs,
                                   input int n_typed = PREDICT,
                                   input sample_t tl = '0, input sample_t tr = '0);
    stim_row_t row;
    row.kind        = ROW_ITEM;
    row.reg_idx     = '0;
    row.reg_val     = '0;
    row.left        = l;
    row.right       = r;
    row.restart     = rs;
    row.n_typed     = n_typed;
    row.typed_left  = tl;
    row.typed_right = tr;
    script.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DW-1:0] value);
    stim_row_t row;
    row.kind        = ROW_CFG;
    row.reg_idx     = idx;
    row.reg_val     = value;
    row.left        = '0;
    row.right       = '0;
    row.restart     = 1'b0;
    row.n_typed     = 0;
    row.typed_left  = '0;
    row.typed_right = '0;
    script.push_back(row);
  endfunction

  // Drop valid, let every expected result arrive, then let the block settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    logic [APB_DW-1:0] got, want, mask;
    want = (idx == REG_ENABLE) ? APB_DW'(model_en) : APB_DW'(model_step);
    mask = (idx == REG_ENABLE) ? APB_DW'(1) : APB_DW'((1 << STEP_W) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) != want)
      report_mismatch((idx == REG_ENABLE) ? "enable readback" : "step readback",
                      got & mask, want);
    @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_ENABLE) model_en = value[0];
    else model_step = value[STEP_W-1:0];
    reg_check(idx);
  endtask

  task automatic send_sample(input sample_t left, input sample_t right, input logic restart,
                             input int n_typed, input sample_t typed_left,
                             input sample_t typed_right);
    point_t pts[$];
    point_t pt;
    int     gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.sample_left  <= left;
    in_if.sample_right <= right;
    in_if.restart      <= restart;
    do @(posedge clk_i); while (!in_if.ready);
    resample_item(left, right, restart, pts);
    if (n_typed == PREDICT) begin
      foreach (pts[i]) pending_points.push_back(pts[i]);
    end else if (n_typed > 0) begin
      pt.left  = typed_left;
      pt.right = typed_right;
      pt.last  = 1'b1;
      pending_points.push_back(pt);
    end
  endtask

  initial begin : check_results
    point_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
        if (pending_points.size() == 0) begin
          report_mismatch("unexpected result, out_left", out_if.out_left, 0);
        end else begin
          want = pending_points.pop_front();
          if (out_if.out_left !== want.left)
            report_mismatch("out_left", out_if.out_left, want.left);
          if (out_if.out_right !== want.right)
            report_mismatch("out_right", out_if.out_right, want.right);
          if (out_if.last !== want.last)
            report_mismatch("last", out_if.last, want.last);
        end
        results_seen++;
      end
    end
  end

  initial begin : drive_ready
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    bit       hold_done;
    out_if.ready = 1'b0;
    mode      = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          RX_FREE:   out_if.ready <= 1'b1;
          RX_RANDOM: out_if.ready <= ($urandom_range(0, 2) != 0);
          default:   out_if.ready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    stim_row_t         row;
    logic [APB_DW-1:0] step;
    logic              restart;
    int                ph;
    int                k;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.sample_left  = '0;
    in_if.sample_right = '0;
    in_if.restart      = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    model_en           = 1'b0;
    model_step         = STEP_RESET;
    model_fill         = 0;
    model_pos          = '0;
    foreach (model_win[i, j]) model_win[i][j] = '0;
    foreach (last_drawn[i]) last_drawn[i] = '0;

    // disabled: dropped, restart too
    add_item(S_MAX, S_MIN, 1'b1, 0);
    add_cfg(REG_ENABLE, 32'd1);
    // unity step: each result is the sample two items back
    add_item(S_MAX, S_MIN, 1'b1, 0);
    add_item(S_MIN, S_MAX, 1'b0, 0);
    add_item(24'sd0, -24'sd1, 1'b0, 1, S_MAX, S_MIN);
    add_item(24'sd1, 24'sd0, 1'b0, 1, S_MIN, S_MAX);
    add_cfg(REG_ENABLE, 32'd0);
    add_item(24'sd100, 24'sd200, 1'b1, 0);
    add_cfg(REG_ENABLE, 32'd1);
    add_item(-24'sd1, 24'sd1, 1'b0, 1, 24'sd0, -24'sd1);
    add_item(24'sd5, -24'sd5, 1'b1, 0);
    add_item(24'sd6, -24'sd6, 1'b0, 0);
    add_item(24'sd7, -24'sd7, 1'b0, 1, 24'sd5, -24'sd5);
    // half step across full-scale swings: overshoot and undershoot saturate
    add_cfg(REG_STEP, STEP_HALF);
    add_item(S_MIN, S_MAX, 1'b1);
    add_item(S_MAX, S_MIN, 1'b0);
    add_item(S_MAX, S_MIN, 1'b0);
    add_item(S_MIN, S_MAX, 1'b0);
    add_item(S_MIN, S_MAX, 1'b0);
    add_item(S_MAX, S_MIN, 1'b0);
    // step below the floor: result cap per item, position clamps at zero
    add_cfg(REG_STEP, STEP_SUB_MIN);
    add_item(24'sd1000, -24'sd2000, 1'b1);
    add_item(24'sd300000, -24'sd40000, 1'b0);
    add_item(-24'sd7000000, 24'sd8000000, 1'b0);
    add_item(24'sd2000000, -24'sd3000000, 1'b0);
    add_item(24'sd0, 24'sd0, 1'b0);
    // largest step: most items give no result
    add_cfg(REG_STEP, STEP_MAX);
    add_item(24'sd1, 24'sd2, 1'b1, 0);
    add_item(24'sd3, 24'sd4, 1'b0, 0);
    add_item(24'sd5, 24'sd6, 1'b0, 1, 24'sd1, 24'sd2);
    add_item(24'sd7, 24'sd8, 1'b0, 0);
    add_item(24'sd9, 24'sd10, 1'b0, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_check(REG_ENABLE);
    reg_check(REG_STEP);

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_CFG) begin
        reg_write(row.reg_idx, row.reg_val);
      end else begin
        send_sample(row.left, row.right, row.restart, row.n_typed,
                    row.typed_left, row.typed_right);
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 3) begin
        reg_write(REG_ENABLE, 32'd0);
        repeat (5) send_sample(draw_sample(0), draw_sample(1), 1'($urandom_range(0, 1)),
                               PREDICT, '0, '0);
        reg_write(REG_ENABLE, 32'd1);
      end
      case (ph)
        0:       step = STEP_UNITY;
        1:       step = STEP_MIN;
        2:       step = $urandom_range(1024, 98303);
        3:       step = $urandom_range(65536, 262143);
        4:       step = STEP_MAX;
        default: step = $urandom_range(1024, 1048575);
      endcase
      reg_write(REG_STEP, step);
      for (k = 0; k < RAND_ITEMS; k++) begin
        // stall the output long enough to back up the input
        if (ph == 0 && k == 4) hold_go <= 1'b1;
        restart = (k == 0 && ph != 3) || ($urandom_range(0, 23) == 0);
        send_sample(draw_sample(0), draw_sample(1), restart, PREDICT, '0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/hvr_pkg.sv
rtl/hvr_in_if.sv
rtl/hvr_out_if.sv
rtl/hvr_regs.sv
rtl/hvr_ctrl.sv
rtl/hvr_dp.sv
rtl/hermite_varispeed_resampler_top.sv
rtl/hvr_checker.sv
sim/tb_top.sv
